// File: src/thv_pkg.sv
`timescale 1ns / 1ps

package thv_pkg;

  localparam logic [31:0] ENDIAN_NATIVE   = 32'h0403_0201;
  localparam logic [31:0] ENDIAN_REVERSED = 32'h0102_0304;
  localparam logic [63:0] ID_HIGH         = 64'hAB4B_5458_2031_31BB;
  localparam logic [31:0] ID_LOW          = 32'h0D0A_1A0A;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_IDENTIFIER = 4'd1;
  localparam logic [3:0] ERR_TYPE_SIZE  = 4'd2;
  localparam logic [3:0] ERR_ENDIAN     = 4'd3;
  localparam logic [3:0] ERR_TYPE_FMT   = 4'd4;
  localparam logic [3:0] ERR_EXTENT     = 4'd5;
  localparam logic [3:0] ERR_CUBE_DIM   = 4'd6;
  localparam logic [3:0] ERR_FACES      = 4'd7;
  localparam logic [3:0] ERR_LEVELS     = 4'd8;

  localparam logic [1:0] DIMS_1 = 2'd1;
  localparam logic [1:0] DIMS_2 = 2'd2;
  localparam logic [1:0] DIMS_3 = 2'd3;

  localparam logic [1:0] TGT_1D   = 2'd0;
  localparam logic [1:0] TGT_2D   = 2'd1;
  localparam logic [1:0] TGT_3D   = 2'd2;
  localparam logic [1:0] TGT_CUBE = 2'd3;

  typedef struct packed {
    logic [63:0] identifier_high;
    logic [31:0] identifier_low;
    logic [31:0] endian_word;
    logic [31:0] element_type;
    logic [31:0] element_type_size;
    logic [31:0] pixel_format;
    logic [31:0] width_raw;
    logic [31:0] height_raw;
    logic [31:0] depth_raw;
    logic [31:0] faces_raw;
    logic [31:0] levels_raw;
  } in_word_t;

  typedef struct packed {
    logic        header_ok;
    logic [3:0]  error_kind;
    logic [1:0]  dimensions;
    logic [1:0]  target_kind;
    logic        is_compressed;
    logic        make_mipmaps;
    logic [31:0] width_fixed;
    logic [31:0] height_fixed;
    logic [31:0] depth_fixed;
    logic [31:0] faces_fixed;
    logic [31:0] levels_fixed;
  } out_word_t;

  // Header fields after byte-order correction.
  typedef struct packed {
    logic        id_ok;
    logic        swap;
    logic        native;
    logic [31:0] gtype;
    logic [31:0] tsize;
    logic [31:0] gfmt;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] d;
    logic [31:0] faces;
    logic [31:0] lv;
  } fixed_t;

  // Compare results and reduced values ready for the final decision.
  typedef struct packed {
    logic        id_ok;
    logic        swap;
    logic        native;
    logic        tsize_bad;
    logic        gtype_zero;
    logic        gfmt_zero;
    logic        w_zero;
    logic        h_nz;
    logic        d_nz;
    logic        faces6;
    logic        faces1;
    logic        gen;
    logic        sh_big;
    logic [4:0]  sh;
    logic [31:0] maxd;
    logic [31:0] levels;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] d;
    logic [31:0] faces;
  } flags_t;

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// File: src/thv_swap_stage.sv
`timescale 1ns / 1ps

module thv_swap_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  logic              in_valid,
  input  thv_pkg::in_word_t in_word,
  output logic              valid_r,
  output thv_pkg::fixed_t   data_r
);

  logic            valid_nxt;
  logic            swap;
  thv_pkg::fixed_t data_nxt;

  function automatic logic [31:0] fix(input logic [31:0] v, input logic s);
    return s ? thv_pkg::bswap32(v) : v;
  endfunction

  always_comb begin
    swap               = (in_word.endian_word == thv_pkg::ENDIAN_REVERSED);
    data_nxt.id_ok     = (in_word.identifier_high == thv_pkg::ID_HIGH) &&
                         (in_word.identifier_low == thv_pkg::ID_LOW);
    data_nxt.swap      = swap;
    data_nxt.native    = (in_word.endian_word == thv_pkg::ENDIAN_NATIVE);
    data_nxt.gtype     = fix(in_word.element_type, swap);
    data_nxt.tsize     = fix(in_word.element_type_size, swap);
    data_nxt.gfmt      = fix(in_word.pixel_format, swap);
    data_nxt.w         = fix(in_word.width_raw, swap);
    data_nxt.h         = fix(in_word.height_raw, swap);
    data_nxt.d         = fix(in_word.depth_raw, swap);
    data_nxt.faces     = fix(in_word.faces_raw, swap);
    data_nxt.lv        = fix(in_word.levels_raw, swap);
    valid_nxt          = ld ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: src/thv_check_stage.sv
`timescale 1ns / 1ps

module thv_check_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ld,
  input  logic            in_valid,
  input  thv_pkg::fixed_t in_data,
  output logic            valid_r,
  output thv_pkg::flags_t data_r
);

  logic            valid_nxt;
  logic [31:0]     max_wh;
  logic [31:0]     levels_m1;
  thv_pkg::flags_t data_nxt;

  always_comb begin
    max_wh              = (in_data.h > in_data.w) ? in_data.h : in_data.w;
    data_nxt.id_ok      = in_data.id_ok;
    data_nxt.swap       = in_data.swap;
    data_nxt.native     = in_data.native;
    data_nxt.tsize_bad  = !(in_data.tsize inside {32'd1, 32'd2, 32'd4});
    data_nxt.gtype_zero = (in_data.gtype == '0);
    data_nxt.gfmt_zero  = (in_data.gfmt == '0);
    data_nxt.w_zero     = (in_data.w == '0);
    data_nxt.h_nz       = (in_data.h != '0);
    data_nxt.d_nz       = (in_data.d != '0);
    data_nxt.faces6     = (in_data.faces == 32'd6);
    data_nxt.faces1     = (in_data.faces == 32'd1);
    data_nxt.gen        = (in_data.lv == '0);
    // A zero level count stands for one level, so the shift is then zero.
    levels_m1           = data_nxt.gen ? '0 : (in_data.lv - 32'd1);
    data_nxt.sh_big     = (levels_m1[31:5] != '0);
    data_nxt.sh         = levels_m1[4:0];
    data_nxt.maxd       = (in_data.d > max_wh) ? in_data.d : max_wh;
    data_nxt.levels     = data_nxt.gen ? 32'd1 : in_data.lv;
    data_nxt.w          = in_data.w;
    data_nxt.h          = in_data.h;
    data_nxt.d          = in_data.d;
    data_nxt.faces      = in_data.faces;
    valid_nxt           = ld ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: src/thv_decide_stage.sv
`timescale 1ns / 1ps

module thv_decide_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  logic               in_valid,
  input  thv_pkg::flags_t    in_data,
  output logic               valid_r,
  output thv_pkg::out_word_t data_r
);

  logic               valid_nxt;
  logic               too_many;
  logic [3:0]         err;
  thv_pkg::out_word_t data_nxt;

  always_comb begin
    too_many = in_data.sh_big || (in_data.maxd < (32'd1 << in_data.sh));

    if (!in_data.id_ok) begin
      err = thv_pkg::ERR_IDENTIFIER;
    end else if (in_data.swap && in_data.tsize_bad) begin
      err = thv_pkg::ERR_TYPE_SIZE;
    end else if (!in_data.swap && !in_data.native) begin
      err = thv_pkg::ERR_ENDIAN;
    end else if (in_data.gtype_zero != in_data.gfmt_zero) begin
      err = thv_pkg::ERR_TYPE_FMT;
    end else if (in_data.w_zero || (in_data.d_nz && !in_data.h_nz)) begin
      err = thv_pkg::ERR_EXTENT;
    end else if (in_data.faces6 && (in_data.d_nz || !in_data.h_nz)) begin
      err = thv_pkg::ERR_CUBE_DIM;
    end else if (!in_data.faces6 && !in_data.faces1) begin
      err = thv_pkg::ERR_FACES;
    end else if (too_many) begin
      err = thv_pkg::ERR_LEVELS;
    end else begin
      err = thv_pkg::ERR_NONE;
    end

    if (in_data.d_nz) begin
      data_nxt.dimensions  = thv_pkg::DIMS_3;
      data_nxt.target_kind = thv_pkg::TGT_3D;
    end else if (in_data.h_nz) begin
      data_nxt.dimensions  = thv_pkg::DIMS_2;
      data_nxt.target_kind = in_data.faces6 ? thv_pkg::TGT_CUBE : thv_pkg::TGT_2D;
    end else begin
      data_nxt.dimensions  = thv_pkg::DIMS_1;
      data_nxt.target_kind = thv_pkg::TGT_1D;
    end

    data_nxt.header_ok     = (err == thv_pkg::ERR_NONE);
    data_nxt.error_kind    = err;
    data_nxt.is_compressed = in_data.gtype_zero && in_data.gfmt_zero;
    data_nxt.make_mipmaps  = in_data.gen;
    data_nxt.width_fixed   = in_data.w;
    data_nxt.height_fixed  = in_data.h;
    data_nxt.depth_fixed   = in_data.d;
    data_nxt.faces_fixed   = in_data.faces;
    data_nxt.levels_fixed  = in_data.levels;
    valid_nxt              = ld ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: src/texture_header_validator.sv
`timescale 1ns / 1ps
// Texture header validator.
// The input channel (in_valid, in_stall, in_word) carries the parsed fields
// of one texture file header per word. The output channel (out_valid,
// out_stall, out_word) returns one word per header: the pass flag, the
// first failing check as an error code, and the byte-order corrected and
// derived fields.
// A word passes through three register stages: byte-order correction and
// identifier compare, field compares and maximum dimension, then the level
// limit and the error priority into the output register. A word is loaded
// into the first stage at its accepting edge, and out_valid rises once it
// has moved on through the second stage into the output register.
// One word is taken every cycle while in_stall is low.
// Each stage holds its word while the stage after it is full and stalled,
// so an empty stage still takes a word; in_stall rises only when all three
// stages are full and out_stall is high. No word is lost or repeated.
// Reset clears the stage valid bits, leaving the pipeline empty.

module texture_header_validator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  thv_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output thv_pkg::out_word_t out_word
);

  logic            v1;
  logic            v2;
  logic            en1;
  logic            en2;
  logic            en3;
  thv_pkg::fixed_t s1_data;
  thv_pkg::flags_t s2_data;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  thv_swap_stage u_swap (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (en1),
    .in_valid (in_valid),
    .in_word  (in_word),
    .valid_r  (v1),
    .data_r   (s1_data)
  );

  thv_check_stage u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (en2),
    .in_valid (v1),
    .in_data  (s1_data),
    .valid_r  (v2),
    .data_r   (s2_data)
  );

  thv_decide_stage u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (en3),
    .in_valid (v2),
    .in_data  (s2_data),
    .valid_r  (out_valid),
    .data_r   (out_word)
  );

endmodule
